// File: rtl/accelerometer_tilt_angles_assert.svh
// Assertion macros for the tilt angle block checker.
`ifndef ACCELEROMETER_TILT_ANGLES_ASSERT_SVH
`define ACCELEROMETER_TILT_ANGLES_ASSERT_SVH
// Implication checked on every rising clock edge, masked during reset.
`define TILT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tilt assertion failed");
// Next-cycle implication.
`define TILT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tilt assertion failed");
`endif

// File: rtl/acctilt_pkg.sv
// Package: shared constants and CORDIC arctangent table for the tilt block.
package acctilt_pkg;
    localparam int FRAC_BITS = 16;
    localparam int TABLE_LEN = 24;
    localparam int ACC_W     = 28;
    localparam int REG_CAL_LOW  = 0;
    localparam int REG_CAL_HIGH = 1;

    // Arctangent of 2^-i in degrees, 16 fractional bits, rounded.
    function automatic logic signed [ACC_W-1:0] atan_deg(input int i);
        logic signed [ACC_W-1:0] v;
        begin
            case (i)
                0: v = 28'sd2949120;  1: v = 28'sd1740967;  2: v = 28'sd919879;
                3: v = 28'sd466945;   4: v = 28'sd234379;   5: v = 28'sd117304;
                6: v = 28'sd58666;    7: v = 28'sd29335;    8: v = 28'sd14668;
                9: v = 28'sd7334;    10: v = 28'sd3667;    11: v = 28'sd1833;
                12: v = 28'sd917;    13: v = 28'sd458;     14: v = 28'sd229;
                15: v = 28'sd115;    16: v = 28'sd57;      17: v = 28'sd29;
                18: v = 28'sd14;     19: v = 28'sd7;       20: v = 28'sd4;
                21: v = 28'sd2;      22: v = 28'sd1;
                default: v = 28'sd0;
            endcase
            return v;
        end
    endfunction
endpackage

// File: rtl/acctilt_map.sv
// Axis map pipeline: raw ADC sample to -90..90 through a pipelined restoring divider.
module acctilt_map #(
    parameter int ADC_BITS = 10
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [ADC_BITS-1:0] i_v,
    input  logic [ADC_BITS-1:0] i_lo,
    input  logic [ADC_BITS-1:0] i_hi,
    output logic signed [7:0]   o_a
);
    localparam int DW = ADC_BITS + 2;
    localparam int NW = DW + 8;
    localparam int QS = NW;

    logic signed [DW-1:0] w_a, w_b, w_d;
    logic signed [NW:0]   w_num;
    logic                 w_eq;

    always_comb begin
        w_a = (i_lo > i_hi) ? DW'(i_lo) + DW'(1) : DW'(i_lo);
        w_b = (i_hi > i_lo) ? DW'(i_hi) + DW'(1) : DW'(i_hi);
        w_d = w_b - w_a;
        w_eq = (w_a == w_b);
        w_num = (NW+1)'(signed'(DW'(i_v)) - w_a) * (NW+1)'(181);
    end

    // stage 1: signed numerator and divisor
    logic signed [NW:0]   r_num;
    logic signed [DW-1:0] r_den;
    logic                 r_eq;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= w_num;
            r_den <= w_d;
            r_eq  <= w_eq;
        end
    end

    // restoring divider on magnitudes, one quotient bit per stage;
    // slot 0 holds the magnitudes and the sign of the quotient
    logic [NW-1:0] r_rem [QS+1];
    logic [NW-1:0] r_quo [QS+1];
    logic [DW-1:0] r_dv  [QS+1];
    logic          r_ng  [QS+1];
    logic          r_eqs [QS+1];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_quo[0] <= r_num[NW] ? NW'(-r_num) : NW'(r_num);
            r_dv[0]  <= r_den[DW-1] ? DW'(-r_den) : DW'(r_den);
            r_ng[0]  <= r_num[NW] ^ r_den[DW-1];
            r_eqs[0] <= r_eq;
        end
    end
    for (genvar k = 0; k < QS; k++) begin : g_div
        logic [NW:0] w_t;
        assign w_t = {r_rem[k], r_quo[k][NW-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_t >= (NW+1)'(r_dv[k])) begin
                    r_rem[k+1] <= NW'(w_t - (NW+1)'(r_dv[k]));
                    r_quo[k+1] <= {r_quo[k][NW-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= NW'(w_t);
                    r_quo[k+1] <= {r_quo[k][NW-2:0], 1'b0};
                end
                r_dv[k+1]  <= r_dv[k];
                r_ng[k+1]  <= r_ng[k];
                r_eqs[k+1] <= r_eqs[k];
            end
        end
    end

    // final: zero when the bounds are equal, else sign, offset, clamp
    logic signed [NW+1:0] w_m;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_eqs[QS]) o_a <= 8'sd0;
            else if (w_m < -(NW+2)'(90)) o_a <= -8'sd90;
            else if (w_m > (NW+2)'(90)) o_a <= 8'sd90;
            else o_a <= 8'(w_m);
        end
    end
    assign w_m = (r_ng[QS] ? -signed'((NW+2)'(r_quo[QS])) : signed'((NW+2)'(r_quo[QS])))
                 - (NW+2)'(90);
endmodule

// File: rtl/acctilt_cordic.sv
// Pipelined CORDIC vectoring unit with fold and clamp of the angle.
module acctilt_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic signed [7:0] i_y,
    input  logic signed [7:0] i_x,
    output logic signed [7:0] o_tilt
);
    localparam int NS = (CORDIC_STEPS > acctilt_pkg::TABLE_LEN) ?
                        acctilt_pkg::TABLE_LEN : CORDIC_STEPS;
    localparam int AW = acctilt_pkg::ACC_W;
    localparam int VW = 27;

    logic signed [VW-1:0] r_cx [NS+1];
    logic signed [VW-1:0] r_cy [NS+1];
    logic signed [AW-1:0] r_ac [NS+1];
    logic                 r_sp [NS+1];
    logic signed [AW-1:0] w_sac;

    // stage 0: axis special cases and left-half-plane negation
    always_comb begin
        if (i_y == 0) w_sac = (i_x < 0) ? AW'(180*65536) : '0;
        else if (i_x == 0) w_sac = (i_y > 0) ? AW'(90*65536) : -AW'(90*65536);
        else if (i_x < 0) w_sac = (i_y >= 0) ? AW'(180*65536) : -AW'(180*65536);
        else w_sac = '0;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sp[0] <= (i_y == 0) || (i_x == 0);
            r_ac[0] <= w_sac;
            if (i_x < 0) begin
                r_cx[0] <= -(VW'(i_x) <<< 16);
                r_cy[0] <= -(VW'(i_y) <<< 16);
            end else begin
                r_cx[0] <= VW'(i_x) <<< 16;
                r_cy[0] <= VW'(i_y) <<< 16;
            end
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < NS; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sp[i+1] <= r_sp[i];
                if (r_sp[i]) begin
                    r_cx[i+1] <= r_cx[i];
                    r_cy[i+1] <= r_cy[i];
                    r_ac[i+1] <= r_ac[i];
                end else if (r_cy[i] >= 0) begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_ac[i+1] <= r_ac[i] + acctilt_pkg::atan_deg(i);
                end else begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_ac[i+1] <= r_ac[i] - acctilt_pkg::atan_deg(i);
                end
            end
        end
    end

    // offset by 180 and truncate toward zero
    logic signed [AW-1:0] w_t;
    logic signed [AW-1:0] w_n;
    logic signed [AW-1:0] r_n;
    always_comb begin
        w_t = r_ac[NS] + AW'(180*65536);
        w_n = (w_t >= 0) ? (w_t >>> acctilt_pkg::FRAC_BITS)
                         : -((-w_t) >>> acctilt_pkg::FRAC_BITS);
    end
    always_ff @(posedge i_clk) begin
        if (i_en) r_n <= w_n;
    end

    // fold about level and clamp
    logic signed [AW-1:0] w_r;
    always_comb begin
        if (r_n <= AW'(180)) w_r = -r_n;
        else begin
            w_r = AW'(361) - r_n;
            if (w_r < 0) w_r = '0;
            if (w_r > AW'(179)) w_r = AW'(179);
        end
        if (w_r < -AW'(90)) w_r = -AW'(90);
        if (w_r > AW'(90)) w_r = AW'(90);
    end
    always_ff @(posedge i_clk) begin
        if (i_en) o_tilt <= 8'(w_r);
    end
endmodule

// File: rtl/accelerometer_tilt_angles.sv
// Top level: tilt angle pipeline with stream handshake and config registers.
// Channel  | Direction | Payload
// s_axis   | in        | tdata: x_raw, y_raw, z_raw
// m_axis   | out       | tdata: x_tilt, y_tilt
// config   | in        | cal_low (0), cal_high (1)
// One transaction per cycle while the output is not stalled;
// map takes two input stages, ADC_BITS+10 quotient stages and an output stage;
// CORDIC takes an entry stage, one stage per step, a truncate and an output stage.
// Synchronous active-low reset clears the valid bits and loads cal_low 265, cal_high 402.
// The whole pipeline advances when the output register is empty or taken.
module accelerometer_tilt_angles #(
    parameter int ADC_BITS     = 10,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // x_raw, y_raw, z_raw from bit 0
    input  logic [((3*ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // x_tilt [7:0], y_tilt [15:8]
    output logic [15:0]           m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [ADC_BITS-1:0]   i_cfg_data
);
    localparam int NS = (CORDIC_STEPS > acctilt_pkg::TABLE_LEN) ?
                        acctilt_pkg::TABLE_LEN : CORDIC_STEPS;
    localparam int LAT = (ADC_BITS + 13) + (NS + 3);

    logic [ADC_BITS-1:0] r_lo, r_hi;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= ADC_BITS'(265);
            r_hi <= ADC_BITS'(402);
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'(acctilt_pkg::REG_CAL_LOW)) r_lo <= i_cfg_data;
            else r_hi <= i_cfg_data;
        end
    end

    logic w_en;
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
    end
    assign m_axis_tvalid = r_vld[LAT-1];

    logic signed [7:0] w_xa, w_ya, w_za, w_xt, w_yt;
    acctilt_map #(.ADC_BITS(ADC_BITS)) u_mx (.i_clk, .i_en(w_en),
        .i_v(s_axis_tdata[ADC_BITS-1:0]), .i_lo(r_lo), .i_hi(r_hi), .o_a(w_xa));
    acctilt_map #(.ADC_BITS(ADC_BITS)) u_my (.i_clk, .i_en(w_en),
        .i_v(s_axis_tdata[2*ADC_BITS-1:ADC_BITS]), .i_lo(r_lo), .i_hi(r_hi), .o_a(w_ya));
    acctilt_map #(.ADC_BITS(ADC_BITS)) u_mz (.i_clk, .i_en(w_en),
        .i_v(s_axis_tdata[3*ADC_BITS-1:2*ADC_BITS]), .i_lo(r_lo), .i_hi(r_hi), .o_a(w_za));

    acctilt_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cx (.i_clk, .i_en(w_en),
        .i_y(-w_ya), .i_x(-w_za), .o_tilt(w_xt));
    acctilt_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cy (.i_clk, .i_en(w_en),
        .i_y(-w_xa), .i_x(-w_za), .o_tilt(w_yt));

    assign m_axis_tdata = {w_yt, w_xt};
endmodule

// File: rtl/acctilt_checker.sv
// Port-level checker for the tilt block, bound to the top level.
`include "accelerometer_tilt_angles_assert.svh"
module acctilt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    // output fields and handshake terms
    logic signed [7:0] w_x, w_y;
    logic              w_x_ok, w_y_ok, w_stall;
    assign w_x     = m_axis_tdata[7:0];
    assign w_y     = m_axis_tdata[15:8];
    assign w_x_ok  = (w_x >= -8'sd90) && (w_x <= 8'sd90);
    assign w_y_ok  = (w_y >= -8'sd90) && (w_y <= 8'sd90);
    assign w_stall = m_axis_tvalid && !m_axis_tready;

    `TILT_ASSERT_IMPL(a_x_range, i_clk, i_rst_n, m_axis_tvalid, w_x_ok)
    `TILT_ASSERT_IMPL(a_y_range, i_clk, i_rst_n, m_axis_tvalid, w_y_ok)
    `TILT_ASSERT_IMPL(a_ready, i_clk, i_rst_n, !w_stall, s_axis_tready)
    `TILT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, w_stall, $stable(m_axis_tdata))
    `TILT_ASSERT_NEXT(a_hold_vld, i_clk, i_rst_n, w_stall, m_axis_tvalid)
endmodule

bind accelerometer_tilt_angles acctilt_checker u_chk (.*);
